[rtl/hclr_pkg.sv]
// shared types, codes and decode helpers for the hex command line receiver
package hclr_pkg;

  // input item codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_E         = 8'h65;
  localparam logic [7:0] CH_V         = 8'h76;
  localparam logic [7:0] CH_P         = 8'h70;
  localparam logic [7:0] CH_C         = 8'h63;

  localparam logic [15:0] IDLE_LIMIT_RST = 16'd100;
  localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

  // five words of eight digits after the command byte: bytes 0..40 are read
  localparam int         NUM_WORDS = 5;
  localparam logic [5:0] LAST_IDX  = 6'd40;

  localparam logic [31:0] HALF_BITS = 32'h3F00_0000;
  localparam logic [31:0] PINF_BITS = 32'h7F80_0000;

  typedef enum logic [2:0] {
    K_ENABLE   = 3'd0,
    K_VELOCITY = 3'd1,
    K_PARAMS   = 3'd2,
    K_MOTOR    = 3'd3,
    K_UNREC    = 3'd4,
    K_RESTART  = 3'd5
  } kind_t;

  typedef enum logic {
    JOB_LINE    = 1'b0,
    JOB_RESTART = 1'b1
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_READ   = 2'd1,
    BK_DRAIN  = 2'd2,
    BK_FINISH = 2'd3
  } back_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic kind_t cmd_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_E:    k = K_ENABLE;
      CH_V:    k = K_VELOCITY;
      CH_P:    k = K_PARAMS;
      CH_C:    k = K_MOTOR;
      default: k = K_UNREC;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] cmd_words(input kind_t k);
    logic [2:0] n;
    case (k)
      K_ENABLE:   n = 3'd1;
      K_VELOCITY: n = 3'd2;
      K_PARAMS:   n = 3'd3;
      K_MOTOR:    n = 3'd5;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    case (c) inside
      [8'h30:8'h39]: h.val = 4'(c - 8'h30);
      [8'h61:8'h66]: h.val = 4'(c - 8'h57);
      [8'h41:8'h46]: h.val = 4'(c - 8'h37);
      default:       h.ok  = 1'b0;
    endcase
    return h;
  endfunction

  // positive, above 0.5, not nan
  function automatic logic above_half(input logic [31:0] x);
    return !x[31] && (x > HALF_BITS) && (x <= PINF_BITS);
  endfunction

endpackage

[rtl/hex_command_line_receiver.sv]
// top level of the hex command line receiver
// results: a plain byte is written to the store and gives no result; a line end gives its
//   result after the back reads store bytes 0..40 at one byte a cycle, via the result register
// flow: bytes after a line end stall until the read sweep is done; ticks are taken every
//   cycle while the job queue has room, and a restart result goes through the job queue
// reset: synchronous, active low; the store is then zeroed with in_stall held high
module hex_command_line_receiver #(
  parameter int LINE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [31:0] out_word2,
  output logic [31:0] out_word3,
  output logic [31:0] out_word4,
  output logic [2:0]  out_bool_flags,
  output logic [15:0] out_messages_seen,
  // idle tick limit register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int AW = $clog2(LINE_BYTES);

  // store write port from front to back
  logic          st_we;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_data;

  // job queue
  logic           push, q_full, q_valid, q_pop;
  hclr_pkg::job_t push_job, q_job;

  // back has finished reading the store for the pending line
  logic line_done;

  // front: classifies each request, owns write position, idle count and limit
  hclr_front #(
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_rx_byte  (in_rx_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .st_we       (st_we),
    .st_addr     (st_addr),
    .st_data     (st_data),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full),
    .line_done   (line_done)
  );

  // short queue keeps line and restart jobs in arrival order
  hclr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (q_pop)
  );

  // back: reads the line back, decodes words, holds the message count and result
  hclr_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .st_we             (st_we),
    .st_addr           (st_addr),
    .st_data           (st_data),
    .q_valid           (q_valid),
    .q_job             (q_job),
    .q_pop             (q_pop),
    .line_done         (line_done),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_word0         (out_word0),
    .out_word1         (out_word1),
    .out_word2         (out_word2),
    .out_word3         (out_word3),
    .out_word4         (out_word4),
    .out_bool_flags    (out_bool_flags),
    .out_messages_seen (out_messages_seen)
  );

endmodule

[rtl/hclr_fifo.sv]
// two-entry job queue between the front and the back
module hclr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hclr_pkg::job_t    push_job,
  output logic              full,
  output logic              q_valid,
  output hclr_pkg::job_t    q_job,
  input  logic              pop
);

  hclr_pkg::job_t slot_r [2];
  logic           wptr_r;
  logic           rptr_r;
  logic [1:0]     cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/hclr_front.sv]
// front end: accepts bytes and ticks, writes the line store, detects line ends
module hclr_front #(
  parameter int LINE_BYTES = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          cfg_wr_en,
  input  logic [15:0]                   cfg_wr_data,
  output logic                          st_we,
  output logic [$clog2(LINE_BYTES)-1:0] st_addr,
  output logic [7:0]                    st_data,
  output logic                          push,
  output hclr_pkg::job_t                push_job,
  input  logic                          q_full,
  input  logic                          line_done
);

  localparam int             PW       = $clog2(LINE_BYTES);
  localparam logic [PW-1:0]  POS_WRAP = PW'(LINE_BYTES - 2);
  localparam logic [PW-1:0]  CLR_LAST = PW'(LINE_BYTES - 1);

  logic          clr_active_r;
  logic [PW-1:0] clr_cnt_r;
  logic [PW-1:0] pos_r,     pos_nxt;
  logic          last_bs_r;
  logic [15:0]   idle_r,    idle_nxt;
  logic [15:0]   limit_r;
  logic          pending_r;

  logic accept, is_byte, is_tick, line_end, tick_fire;
  logic [15:0] idle_inc;

  assign in_stall = clr_active_r || q_full || (pending_r && (in_op == hclr_pkg::OP_BYTE));
  assign accept   = in_valid && !in_stall;
  assign is_byte  = accept && (in_op == hclr_pkg::OP_BYTE);
  assign is_tick  = accept && (in_op == hclr_pkg::OP_TICK);

  // escaped line end only counts once two bytes are on the line
  assign line_end = (in_rx_byte == hclr_pkg::CH_LF) || (in_rx_byte == hclr_pkg::CH_CR) ||
                    ((pos_r > PW'(1)) && last_bs_r &&
                     ((in_rx_byte == hclr_pkg::CH_N) || (in_rx_byte == hclr_pkg::CH_R)));

  assign idle_inc  = (idle_r == hclr_pkg::IDLE_MAX) ? idle_r : idle_r + 16'd1;
  assign tick_fire = idle_inc > limit_r;

  assign push     = (is_byte && line_end) || (is_tick && tick_fire);
  assign push_job = is_tick ? hclr_pkg::JOB_RESTART : hclr_pkg::JOB_LINE;

  // store write port, shared with the clearing sweep
  assign st_we   = clr_active_r || is_byte;
  assign st_addr = clr_active_r ? clr_cnt_r : pos_r;
  assign st_data = clr_active_r ? 8'd0 : in_rx_byte;

  always_comb begin
    pos_nxt  = pos_r;
    idle_nxt = idle_r;
    if (is_byte) begin
      if (line_end) begin
        pos_nxt  = '0;
        idle_nxt = 16'd0;
      end else begin
        pos_nxt = (pos_r == POS_WRAP) ? '0 : pos_r + PW'(1);
      end
    end else if (is_tick) begin
      idle_nxt = idle_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      pos_r        <= '0;
      last_bs_r    <= 1'b0;
      idle_r       <= 16'd0;
      limit_r      <= hclr_pkg::IDLE_LIMIT_RST;
      pending_r    <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + PW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          clr_active_r <= 1'b0;
        end
      end
      pos_r  <= pos_nxt;
      idle_r <= idle_nxt;
      if (is_byte) begin
        last_bs_r <= (in_rx_byte == hclr_pkg::CH_BACKSLASH);
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (is_byte && line_end) begin
        pending_r <= 1'b1;
      end else if (line_done) begin
        pending_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/hclr_back.sv]
// back end: line store, command and hex word decode, result register
module hclr_back #(
  parameter int LINE_BYTES = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          st_we,
  input  logic [$clog2(LINE_BYTES)-1:0] st_addr,
  input  logic [7:0]                    st_data,
  input  logic                          q_valid,
  input  hclr_pkg::job_t                q_job,
  output logic                          q_pop,
  output logic                          line_done,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_kind,
  output logic [31:0]                   out_word0,
  output logic [31:0]                   out_word1,
  output logic [31:0]                   out_word2,
  output logic [31:0]                   out_word3,
  output logic [31:0]                   out_word4,
  output logic [2:0]                    out_bool_flags,
  output logic [15:0]                   out_messages_seen
);

  localparam int AW = $clog2(LINE_BYTES);

  logic [7:0] mem [LINE_BYTES];

  hclr_pkg::back_state_t state_r, state_nxt;

  logic [5:0]  rd_cnt_r;
  logic [7:0]  rd_data_r;
  logic        dv_r;
  logic [5:0]  di_r;
  hclr_pkg::kind_t kind_r;
  logic [2:0]  nwords_r;
  logic [31:0] w_r [hclr_pkg::NUM_WORDS];
  logic        stop_r;
  logic [15:0] recog_r;

  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [31:0] out_w_r [hclr_pkg::NUM_WORDS];
  logic [2:0]  out_flags_r;
  logic [15:0] out_msgs_r;

  logic out_free, start_line, load_restart, load_line;
  logic [5:0] dm1;
  logic [2:0] wsel;
  logic stop_eff;
  hclr_pkg::hex_t hd;
  logic [15:0] recog_nxt;

  assign out_free = !out_valid_r || !out_stall;

  // store: one write port from the front, one registered read port
  always_ff @(posedge clk) begin
    if (st_we) begin
      mem[st_addr] <= st_data;
    end
    rd_data_r <= mem[AW'(rd_cnt_r)];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hclr_pkg::BK_IDLE: begin
        if (q_valid && (q_job == hclr_pkg::JOB_LINE)) begin
          state_nxt = hclr_pkg::BK_READ;
        end
      end
      hclr_pkg::BK_READ: begin
        if (rd_cnt_r == hclr_pkg::LAST_IDX) begin
          state_nxt = hclr_pkg::BK_DRAIN;
        end
      end
      hclr_pkg::BK_DRAIN:  state_nxt = hclr_pkg::BK_FINISH;
      hclr_pkg::BK_FINISH: begin
        if (out_free) begin
          state_nxt = hclr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = hclr_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop        = 1'b0;
    start_line   = 1'b0;
    load_restart = 1'b0;
    load_line    = 1'b0;
    line_done    = 1'b0;
    case (state_r)
      hclr_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (q_job == hclr_pkg::JOB_LINE) begin
            q_pop      = 1'b1;
            start_line = 1'b1;
          end else if (out_free) begin
            q_pop        = 1'b1;
            load_restart = 1'b1;
          end
        end
      end
      hclr_pkg::BK_DRAIN:  line_done = 1'b1;
      hclr_pkg::BK_FINISH: load_line = out_free;
      default: ;
    endcase
  end

  // digit position within the current word
  assign dm1      = di_r - 6'd1;
  assign wsel     = dm1[5:3];
  assign stop_eff = (dm1[2:0] == 3'd0) ? 1'b0 : stop_r;
  assign hd       = hclr_pkg::hex_digit(rd_data_r);

  assign recog_nxt = (kind_r != hclr_pkg::K_UNREC) ? recog_r + 16'd1 : recog_r;

  always_ff @(posedge clk) begin
    if (start_line) begin
      rd_cnt_r <= 6'd0;
    end else if (state_r == hclr_pkg::BK_READ) begin
      rd_cnt_r <= rd_cnt_r + 6'd1;
    end
    di_r <= rd_cnt_r;

    if (start_line) begin
      stop_r <= 1'b0;
      for (int k = 0; k < hclr_pkg::NUM_WORDS; k++) begin
        w_r[k] <= 32'd0;
      end
    end else if (dv_r) begin
      if (di_r == 6'd0) begin
        kind_r   <= hclr_pkg::cmd_kind(rd_data_r);
        nwords_r <= hclr_pkg::cmd_words(hclr_pkg::cmd_kind(rd_data_r));
      end else begin
        stop_r <= stop_eff || !hd.ok;
        for (int k = 0; k < hclr_pkg::NUM_WORDS; k++) begin
          if ((wsel == 3'(k)) && (wsel < nwords_r) && hd.ok && !stop_eff) begin
            w_r[k] <= {w_r[k][27:0], hd.val};
          end
        end
      end
    end

    if (load_restart) begin
      out_kind_r  <= hclr_pkg::K_RESTART;
      out_flags_r <= 3'd0;
      out_msgs_r  <= recog_r;
      for (int k = 0; k < hclr_pkg::NUM_WORDS; k++) begin
        out_w_r[k] <= 32'd0;
      end
    end else if (load_line) begin
      out_kind_r  <= kind_r;
      out_flags_r <= {hclr_pkg::above_half(w_r[4]), hclr_pkg::above_half(w_r[1]),
                      hclr_pkg::above_half(w_r[0])};
      out_msgs_r  <= recog_nxt;
      for (int k = 0; k < hclr_pkg::NUM_WORDS; k++) begin
        out_w_r[k] <= w_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hclr_pkg::BK_IDLE;
      dv_r        <= 1'b0;
      recog_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= (state_r == hclr_pkg::BK_READ);
      if (load_line) begin
        recog_r <= recog_nxt;
      end
      if (load_restart || load_line) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_word0         = out_w_r[0];
  assign out_word1         = out_w_r[1];
  assign out_word2         = out_w_r[2];
  assign out_word3         = out_w_r[3];
  assign out_word4         = out_w_r[4];
  assign out_bool_flags    = out_flags_r;
  assign out_messages_seen = out_msgs_r;

endmodule
